[design/assert_macros.svh]
// Assertion macros shared by the address list modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that an expression holds at every clock edge out of reset.
`define LRAL_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition is followed by a consequence on the next edge.
`define LRAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LRAL_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define LRAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/lral_pkg.sv]
// Shared types and constants of the recency-ordered address list.
package lral_pkg;

    localparam int DEPTH_DEF      = 8;
    localparam int ADDR_WIDTH_DEF = 48;

    // Request kinds carried on the input side-band.
    localparam logic ACT_TOUCH = 1'b0;
    localparam logic ACT_FIND  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch a request and its lookup result
        logic commit;   // apply the list update and load the result register
    } t_lral_cmd;

endpackage

[design/lral_dp.sv]
// Datapath of the address list: entry registers, lookup, shift and result register.
`include "assert_macros.svh"

module lral_dp #(
    parameter int DEPTH      = 8,
    parameter int ADDR_WIDTH = 48,
    parameter int CNT_W      = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lral_pkg::t_lral_cmd   i_cmd,
    input  logic                  i_action,
    input  logic [ADDR_WIDTH-1:0] i_addr,
    output logic                  o_present,
    output logic [CNT_W-1:0]      o_count
);
    import lral_pkg::*;

    logic [ADDR_WIDTH-1:0] r_entry [DEPTH];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic                  r_action;
    logic [DEPTH-1:0]      r_hit;
    logic [DEPTH-1:0]      n_hit;
    logic [DEPTH-1:0]      n_from_hit;
    logic                  r_res_present;
    logic [CNT_W-1:0]      r_res_count;
    logic                  present;
    logic                  full;
    logic                  shift;
    logic                  touch;
    logic [CNT_W-1:0]      tail;

    // Parallel lookup against the valid entries only.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_hit[i] = (CNT_W'(i) < r_count) && (r_entry[i] == i_addr);
        end
    end

    // The hit vector is one-hot at most, since an address is never stored twice.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_from_hit[i] = |(r_hit & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));
        end
    end

    assign present = |r_hit;
    assign full    = (r_count == CNT_W'(DEPTH));
    assign touch   = (r_action == ACT_TOUCH);
    assign shift   = present || full;
    assign tail    = shift ? (r_count - CNT_W'(1)) : r_count;
    assign n_count = (touch && !shift) ? (r_count + CNT_W'(1)) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hit   <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_hit <= n_hit;
            end
            if (i_cmd.commit) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr   <= i_addr;
            r_action <= i_action;
        end
        if (i_cmd.commit) begin
            r_res_present <= present;
            r_res_count   <= n_count;
        end
    end

    // Each entry either takes the new address at the tail or its neighbor
    // behind it when it lies in the part that closes up.
    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        if (g < DEPTH - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_cmd.commit && touch) begin
                    if (CNT_W'(g) == tail) begin
                        r_entry[g] <= r_addr;
                    end else if (shift && (n_from_hit[g] || !present)
                                 && (CNT_W'(g) < tail)) begin
                        r_entry[g] <= r_entry[g+1];
                    end
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_cmd.commit && touch && (CNT_W'(g) == tail)) begin
                    r_entry[g] <= r_addr;
                end
            end
        end
    end

    assign o_present = r_res_present;
    assign o_count   = r_res_count;

    `LRAL_ASSERT_ALWAYS(a_hit_onehot, i_clk, i_rst_n, $onehot0(r_hit), "lookup hit more than one entry")
    `LRAL_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count above depth")
    `LRAL_ASSERT_NEXT(a_find_keeps, i_clk, i_rst_n, i_cmd.commit && (r_action == ACT_FIND), r_count == $past(r_count), "find changed the count")

endmodule

[design/lral_ctrl.sv]
// Controller of the address list: request handshake, update sequencing, result valid.
`include "assert_macros.svh"

module lral_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    output logic                 o_s_ready,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    output lral_pkg::t_lral_cmd  o_cmd
);
    import lral_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // An update may land only when the result register is free or being emptied.
    always_comb begin
        o_cmd.capture = (r_state == ST_IDLE) && i_s_valid;
        o_cmd.commit  = (r_state == ST_UPDATE) && (!r_out_valid || i_m_ready);
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_m_ready;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (o_cmd.commit) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;

    `LRAL_ASSERT_NEXT(a_capture_update, i_clk, i_rst_n, o_cmd.capture, r_state == ST_UPDATE, "capture did not start an update")
    `LRAL_ASSERT_NEXT(a_commit_valid, i_clk, i_rst_n, o_cmd.commit, r_out_valid, "commit did not present a result")
    `LRAL_ASSERT_ALWAYS(a_cmd_exclusive, i_clk, i_rst_n, !(o_cmd.capture && o_cmd.commit), "capture and commit together")

endmodule

[design/lru_recency_address_list.sv]
// Recency-ordered address list (move-to-back LRU) top level.
// A request that is accepted has its result loaded into the output register
// when its update commits, which is held back while an earlier result waits.
// A new request is not taken until the last one commits: the lookup runs in the
// accept cycle, the entry registers shift at commit, and ready drops meanwhile.
// Reset (synchronous, active low) empties the list and drops any pending result.
module lru_recency_address_list #(
    parameter int DEPTH      = lral_pkg::DEPTH_DEF,
    parameter int ADDR_WIDTH = lral_pkg::ADDR_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1),
    parameter int IN_W       = ((ADDR_WIDTH + 7) / 8) * 8,
    parameter int OUT_W      = ((1 + CNT_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Request side: device_address from bit 0, zero padded.
    input  logic [IN_W-1:0]  s_axis_tdata,
    // Request kind: action in bit 0 (touch or find only).
    input  logic [0:0]       s_axis_tuser,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // Result side: was_present in bit 0, then entry_count, zero padded.
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready
);
    import lral_pkg::*;

    t_lral_cmd        cmd;
    logic             res_present;
    logic [CNT_W-1:0] res_count;

    // The controller sequences each request through capture and commit.
    lral_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd)
    );

    // The datapath holds the entries, matches the address when the request is
    // captured, and closes the gap or appends when it commits.
    lral_dp #(
        .DEPTH      (DEPTH),
        .ADDR_WIDTH (ADDR_WIDTH),
        .CNT_W      (CNT_W)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_action  (s_axis_tuser[0]),
        .i_addr    (s_axis_tdata[ADDR_WIDTH-1:0]),
        .o_present (res_present),
        .o_count   (res_count)
    );

    // Result fields packed from the lowest bit up; the padding bits are zero.
    assign m_axis_tdata = OUT_W'({res_count, res_present});

endmodule
